>>> sv/lcg_ksd_pkg.sv
// ----------------------------------------------------------------------------
// lcg_ksd_pkg
// Shared types and constants of the LCG keystream decryptor: key width,
// jump-ahead depth, item and status codes, register map and operand bundles.
// ----------------------------------------------------------------------------
package lcg_ksd_pkg;

  // key width and number of count bits honored by a jump
  localparam int KEY_W      = 32;
  localparam int JUMP_STEPS = 30;
  localparam int CNT_W      = JUMP_STEPS;
  localparam int BIT_W      = (JUMP_STEPS > 1) ? $clog2(JUMP_STEPS) : 1;

  // position and byte widths
  localparam int POS_W  = 32;
  localparam int BYTE_W = 8;

  // configuration port
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_BIT = 2;

  localparam logic REG_KEY_MULT = 1'b0;
  localparam logic REG_KEY_INC  = 1'b1;

  localparam logic [APB_DW-1:0] KEY_MULT_RST = 32'h0000_0007;
  localparam logic [APB_DW-1:0] KEY_INC_RST  = 32'h0000_0003;

  // item kinds
  typedef enum logic [1:0] {
    KIND_OPEN = 2'd0,
    KIND_SEEK = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_SEEK_REFUSED = 2'd1,
    ST_PAST_END     = 2'd2
  } status_e;

  // configured lcg terms
  typedef struct packed {
    logic [APB_DW-1:0] mult;
    logic [APB_DW-1:0] inc;
  } cfg_t;

  // operands of the shared multiply-add: x * y + z
  typedef struct packed {
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] y;
    logic [KEY_W-1:0] z;
  } muladd_op_t;

endpackage

>>> sv/lcg_ksd_apb_regs.sv
// ----------------------------------------------------------------------------
// lcg_ksd_apb_regs
// APB-style register file holding the LCG multiplier and increment.
// ----------------------------------------------------------------------------
module lcg_ksd_apb_regs
  import lcg_ksd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [APB_DW-1:0] mult_q;
  logic [APB_DW-1:0] inc_q;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[REG_IDX_BIT];

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= KEY_MULT_RST;
      inc_q  <= KEY_INC_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_MULT: mult_q <= pwdata;
        REG_KEY_INC:  inc_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_KEY_MULT: prdata = mult_q;
      REG_KEY_INC:  prdata = inc_q;
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.mult = mult_q;
  assign cfg_o.inc  = inc_q;

endmodule

>>> sv/lcg_ksd_muladd.sv
// ----------------------------------------------------------------------------
// lcg_ksd_muladd
// Shared multiply-add unit, x * y + z modulo 2^KEY_W, used for the key step
// and for every term of the jump-ahead recurrence.
// ----------------------------------------------------------------------------
module lcg_ksd_muladd
  import lcg_ksd_pkg::*;
(
  input  muladd_op_t       op_i,
  output logic [KEY_W-1:0] res_o
);

  logic [KEY_W-1:0] prod;

  // low half of the product, then the additive term
  assign prod  = KEY_W'(op_i.x * op_i.y);
  assign res_o = prod + op_i.z;

endmodule

>>> sv/lcg_keystream_seekable_decrypt_top.sv
// ----------------------------------------------------------------------------
// lcg_keystream_seekable_decrypt_top
// Byte-wise LCG keystream decryptor for one archive entry, with jump-ahead
// seeking over a shared multiply-add unit.
// ----------------------------------------------------------------------------
// Usage: one request enters on in_valid_i/in_ready_o: an open (start key and
// entry size), a seek (target position) or a data byte. Each request yields
// exactly one result on out_valid_o/out_ready_i: plain byte, status and the
// position after the request. Multiplier and increment are set over the APB
// port; the user must do it while the block is idle, which is not enforced.
// Flow: open, data and seeks that need no key jump produce their result
// in the cycle after acceptance, so these requests stream at one per cycle
// while the result channel is not stalled. The dword-boundary key step of a
// data byte shares the same cycle. A seek that crosses n dword boundaries
// iterates the jump recurrence on the single multiply-add unit: per count
// bit a key step if the bit is set, then an additive-term step and a
// multiplier-square step, the highest set bit taking only the key step;
// in_ready_o is low meanwhile.
// Reset: key, start key, position and size clear to zero; the multiplier
// resets to 7 and the increment to 3.
// Stall: the result waits in the output register; a new request is taken
// in the cycle the old result is taken, never earlier.
// ----------------------------------------------------------------------------
module lcg_keystream_seekable_decrypt_top
  import lcg_ksd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [31:0]       start_key_i,
  input  logic [31:0]       entry_length_i,
  input  logic [31:0]       target_position_i,
  input  logic [7:0]        cipher_byte_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        plain_byte_o,
  output logic [1:0]        status_o,
  output logic [31:0]       current_position_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic {
    S_IDLE,
    S_JUMP
  } state_e;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_ADD,
    PH_MUL
  } phase_e;

  cfg_t             cfg;
  muladd_op_t       mul_op;
  logic [KEY_W-1:0] mul_res;

  state_e           state_q;
  phase_e           phase_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] init_key_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] entry_q;
  logic [KEY_W-1:0] jm_q;
  logic [KEY_W-1:0] ja_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BIT_W-1:0] jbit_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] plain_q;
  status_e           status_q;
  logic [POS_W-1:0]  out_pos_q;

  logic              acc;
  logic              slot_free;
  logic              seek_back;
  logic [POS_W-1:0]  base_pos;
  logic [POS_W-3:0]  dw_diff;
  logic [CNT_W-1:0]  jump_cnt;
  logic [CNT_W-1:0]  cnt_shift;
  logic              last_bit;
  logic [POS_W-1:0]  pos_inc;
  logic [31:0]       key_lanes;
  logic [BYTE_W-1:0] key_byte;

  // configuration registers
  lcg_ksd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // shared multiply-add
  lcg_ksd_muladd u_muladd (
    .op_i  (mul_op),
    .res_o (mul_res)
  );

  // handshake
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign acc        = in_valid_i && in_ready_o;

  // seek distance in dwords, from the start when going backwards
  assign seek_back = target_position_i < pos_q;
  assign base_pos  = seek_back ? '0 : pos_q;
  assign dw_diff   = target_position_i[POS_W-1:2] - base_pos[POS_W-1:2];
  assign jump_cnt  = CNT_W'(dw_diff);
  assign cnt_shift = cnt_q >> 1;
  assign last_bit  = jbit_q == BIT_W'(JUMP_STEPS - 1);

  // key lane of the current byte
  assign pos_inc   = pos_q + POS_W'(1);
  assign key_lanes = 32'(key_q);
  assign key_byte  = BYTE_W'(key_lanes >> {pos_q[1:0], 3'b000});

  // operand select for the shared unit
  always_comb begin
    mul_op.x = key_q;
    mul_op.y = KEY_W'(cfg.mult);
    mul_op.z = KEY_W'(cfg.inc);
    if (state_q == S_JUMP) begin
      unique case (phase_q)
        PH_KEY: begin
          mul_op.x = key_q;
          mul_op.y = jm_q;
          mul_op.z = ja_q;
        end
        PH_ADD: begin
          mul_op.x = ja_q;
          mul_op.y = jm_q + KEY_W'(1);
          mul_op.z = '0;
        end
        PH_MUL: begin
          mul_op.x = jm_q;
          mul_op.y = jm_q;
          mul_op.z = '0;
        end
        default: ;
      endcase
    end
  end

  // sequencer, entry state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_KEY;
      key_q       <= '0;
      init_key_q  <= '0;
      pos_q       <= '0;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
      plain_q     <= '0;
      status_q    <= ST_OK;
      out_pos_q   <= '0;
      jm_q        <= '0;
      ja_q        <= '0;
      cnt_q       <= '0;
      jbit_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            out_valid_q <= 1'b1;
            plain_q     <= '0;
            status_q    <= ST_OK;
            out_pos_q   <= pos_q;
            unique case (kind_i)
              // open entry
              KIND_OPEN: begin
                key_q      <= KEY_W'(start_key_i);
                init_key_q <= KEY_W'(start_key_i);
                entry_q    <= entry_length_i;
                pos_q      <= '0;
                out_pos_q  <= '0;
              end
              // seek, possibly with a key jump
              KIND_SEEK: begin
                if (target_position_i != pos_q) begin
                  if (target_position_i >= entry_q) begin
                    status_q <= ST_SEEK_REFUSED;
                  end else begin
                    pos_q     <= target_position_i;
                    out_pos_q <= target_position_i;
                    if (seek_back) begin
                      key_q <= init_key_q;
                    end
                    jm_q   <= KEY_W'(cfg.mult);
                    ja_q   <= KEY_W'(cfg.inc);
                    cnt_q  <= jump_cnt;
                    jbit_q <= '0;
                    if (jump_cnt != '0) begin
                      out_valid_q <= 1'b0;
                      state_q     <= S_JUMP;
                      phase_q     <= jump_cnt[0] ? PH_KEY : PH_ADD;
                    end
                  end
                end
              end
              // data byte
              KIND_DATA: begin
                if (pos_q >= entry_q) begin
                  status_q <= ST_PAST_END;
                end else begin
                  plain_q   <= cipher_byte_i ^ key_byte;
                  pos_q     <= pos_inc;
                  out_pos_q <= pos_inc;
                  if (pos_inc[1:0] == 2'b00) begin
                    key_q <= mul_res;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_JUMP: begin
          unique case (phase_q)
            // apply the term of this count bit to the key
            PH_KEY: begin
              key_q <= mul_res;
              if (last_bit || cnt_shift == '0) begin
                state_q     <= S_IDLE;
                out_valid_q <= 1'b1;
              end else begin
                phase_q <= PH_ADD;
              end
            end
            // additive term for the next bit
            PH_ADD: begin
              ja_q    <= mul_res;
              phase_q <= PH_MUL;
            end
            // square the multiplier and move to the next bit
            PH_MUL: begin
              jm_q   <= mul_res;
              cnt_q  <= cnt_shift;
              jbit_q <= jbit_q + BIT_W'(1);
              if (last_bit || cnt_shift == '0) begin
                state_q     <= S_IDLE;
                out_valid_q <= 1'b1;
              end else begin
                phase_q <= cnt_shift[0] ? PH_KEY : PH_ADD;
              end
            end
            default: begin
              state_q     <= S_IDLE;
              out_valid_q <= 1'b1;
            end
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign plain_byte_o       = plain_q;
  assign status_o           = status_q;
  assign current_position_o = out_pos_q;

  // no request is taken while a jump is running
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_JUMP |-> !in_ready_o)
    else $error("request accepted during key jump");

  // a jump only runs toward a position inside the entry
  a_jump_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_JUMP |-> pos_q < entry_q)
    else $error("jump target outside entry");

  // a data byte inside the entry advances the position by one
  a_data_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && kind_i == KIND_DATA && pos_q < entry_q |=> pos_q == $past(pos_q) + 32'd1)
    else $error("data byte did not advance position");

  // requests other than seeks answer in the next cycle
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && kind_i != KIND_SEEK |=> out_valid_o && state_q == S_IDLE)
    else $error("missing result after request");

endmodule

>>> tb/sv/lcg_keystream_seekable_decrypt_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcg_keystream_seekable_decrypt_top_tb
// Self-checking bench for the seekable LCG keystream decryptor. A clocked
// driver feeds open, seek, data and unused requests from a backlog. A clocked
// monitor checks every result against an in-bench model of the key, position
// and entry size. The LCG terms are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module lcg_keystream_seekable_decrypt_top_tb;
  import lcg_ksd_pkg::*;

  localparam int         HALF_PERIOD = 6;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         LONG_HOLD   = 48;
  localparam int         DRAIN_AT    = 260;
  localparam int         SETTLE      = 100;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] start_key;
    logic [31:0] entry_length;
    logic [31:0] target;
    logic [7:0]  cipher;
  } decrypt_req_t;

  typedef struct {
    logic [7:0]  plain;
    logic [1:0]  status;
    logic [31:0] pos;
  } decrypt_result_t;

  // clock, reset and block ports
  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              in_valid_i         = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i             = '0;
  logic [31:0]       start_key_i        = '0;
  logic [31:0]       entry_length_i     = '0;
  logic [31:0]       target_position_i  = '0;
  logic [7:0]        cipher_byte_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i        = 1'b0;
  logic [7:0]        plain_byte_o;
  logic [1:0]        status_o;
  logic [31:0]       current_position_o;
  logic              psel               = 1'b0;
  logic              penable            = 1'b0;
  logic              pwrite             = 1'b0;
  logic [APB_AW-1:0] paddr              = '0;
  logic [APB_DW-1:0] pwdata             = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // request backlog and predicted results
  decrypt_req_t    queued_requests[$];
  decrypt_result_t predicted_outputs[$];
  decrypt_req_t    active_req;
  logic            req_in_flight = 1'b0;
  logic            drain_pause   = 1'b0;
  int              gap_left      = 0;
  int              hold_left     = 0;
  int              long_hold_left = 0;

  // model state and configured terms
  logic [31:0] lcg_mult = KEY_MULT_RST;
  logic [31:0] lcg_inc  = KEY_INC_RST;
  logic [31:0] key_now  = '0;
  logic [31:0] key_base = '0;
  logic [31:0] pos_now  = '0;
  logic [31:0] size_now = '0;
  logic [31:0] planned_size = '0;

  // bookkeeping
  int mismatches     = 0;
  int requests_taken = 0;
  int results_seen   = 0;
  int idle_cycles    = 0;
  int n_open = 0, n_seek = 0, n_data = 0, n_unused = 0;
  int n_refused = 0, n_past_end = 0, n_jumps = 0, n_settings = 1;

  lcg_keystream_seekable_decrypt_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .start_key_i        (start_key_i),
    .entry_length_i     (entry_length_i),
    .target_position_i  (target_position_i),
    .cipher_byte_i      (cipher_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .plain_byte_o       (plain_byte_o),
    .status_o           (status_o),
    .current_position_o (current_position_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  // advance a key by n dword boundaries with squared lcg terms
  function automatic logic [31:0] jump_key(input logic [31:0] k, input logic [31:0] n);
    logic [31:0] m;
    logic [31:0] a;
    m = lcg_mult;
    a = lcg_inc;
    for (int b = 0; b < JUMP_STEPS && b < 32; b++) begin
      if (n[b]) k = k * m + a;
      a = a * (m + 32'd1);
      m = m * m;
    end
    return k;
  endfunction

  // apply one accepted request to the model and queue its result
  function automatic void decrypt_step(input decrypt_req_t r);
    decrypt_result_t res;
    int lane;
    res.plain  = 8'h00;
    res.status = ST_OK;
    case (r.kind)
      KIND_OPEN: begin
        n_open++;
        key_base = r.start_key;
        key_now  = r.start_key;
        size_now = r.entry_length;
        pos_now  = '0;
      end
      KIND_SEEK: begin
        n_seek++;
        if (r.target != pos_now) begin
          if (r.target >= size_now) begin
            res.status = ST_SEEK_REFUSED;
            n_refused++;
          end else begin
            if (r.target < pos_now) begin
              pos_now = '0;
              key_now = key_base;
            end
            key_now = jump_key(key_now, (r.target >> 2) - (pos_now >> 2));
            pos_now = r.target;
            n_jumps++;
          end
        end
      end
      KIND_DATA: begin
        n_data++;
        if (pos_now >= size_now) begin
          res.status = ST_PAST_END;
          n_past_end++;
        end else begin
          lane      = int'(pos_now[1:0]);
          res.plain = r.cipher ^ key_now[8*lane +: 8];
          pos_now   = pos_now + 32'd1;
          if (pos_now[1:0] == 2'd0) key_now = key_now * lcg_mult + lcg_inc;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    res.pos = pos_now;
    predicted_outputs.push_back(res);
  endfunction

  // request driver: one request per handshake, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic offer;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      req_in_flight  = 1'b0;
      gap_left       = 0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        decrypt_step(active_req);
        req_in_flight = 1'b0;
        offer         = 1'b0;
        requests_taken++;
        gap_left = ((requests_taken / 32) % 4 == 1) ? 0 : $urandom_range(0, 6);
        if (requests_taken == DRAIN_AT) drain_pause = 1'b1;
      end
      if (!offer) begin
        if (drain_pause) begin
          if (predicted_outputs.size() == 0) drain_pause = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (queued_requests.size() != 0) begin
          active_req         = queued_requests.pop_front();
          req_in_flight      = 1'b1;
          offer              = 1'b1;
          kind_i            <= active_req.kind;
          start_key_i       <= active_req.start_key;
          entry_length_i    <= active_req.entry_length;
          target_position_i <= active_req.target;
          cipher_byte_i     <= active_req.cipher;
        end
      end
      in_valid_i <= offer;
    end
  end

  // result monitor with random and long back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : take_results
    decrypt_result_t got;
    decrypt_result_t want;
    logic            ready_next;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      hold_left      = 0;
      long_hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.plain  = plain_byte_o;
        got.status = status_o;
        got.pos    = current_position_o;
        if (predicted_outputs.size() == 0) begin
          note_failure($sformatf("result with nothing expected: plain %h status %0d pos %h",
                                 got.plain, got.status, got.pos));
        end else begin
          want = predicted_outputs.pop_front();
          if (got.plain !== want.plain || got.status !== want.status ||
              got.pos !== want.pos)
            note_failure($sformatf(
              "result %0d: expected plain %h status %0d pos %h, got plain %h status %0d pos %h",
              results_seen, want.plain, want.status, want.pos,
              got.plain, got.status, got.pos));
        end
        results_seen++;
        hold_left = ((results_seen / 32) % 4 == 2) ? 0 : $urandom_range(0, 6);
        if (results_seen == 150 || results_seen == 420) long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        ready_next = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready_i <= ready_next;
    end
  end

  // cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("lcg_keystream_seekable_decrypt_top_tb failed");
    $finish;
  end

  // apb register access
  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << REG_IDX_BIT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_KEY_MULT) lcg_mult = value;
    else lcg_inc = value;
  endtask

  task automatic reg_read(input logic idx, input logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(idx) << REG_IDX_BIT;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      note_failure($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || req_in_flight || predicted_outputs.size() != 0)
      @(posedge clk_i);
  endtask

  // reprogram the lcg terms once the block has gone quiet
  task automatic program_lcg(input logic [31:0] mult, input logic [31:0] inc);
    wait_drained();
    repeat (4) @(posedge clk_i);
    reg_write(REG_KEY_MULT, mult);
    reg_write(REG_KEY_INC, inc);
    reg_read(REG_KEY_MULT, mult);
    reg_read(REG_KEY_INC, inc);
    n_settings++;
  endtask

  // every field random, so unused fields toggle too
  function automatic decrypt_req_t scrambled_request();
    decrypt_req_t r;
    r.kind         = 2'($urandom_range(0, 3));
    r.start_key    = $urandom();
    r.entry_length = $urandom();
    r.target       = $urandom();
    r.cipher       = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic void add_open(input logic [31:0] k, input logic [31:0] len);
    decrypt_req_t r;
    r              = scrambled_request();
    r.kind         = KIND_OPEN;
    r.start_key    = k;
    r.entry_length = len;
    planned_size   = len;
    queued_requests.push_back(r);
  endfunction

  function automatic void add_seek(input logic [31:0] t);
    decrypt_req_t r;
    r        = scrambled_request();
    r.kind   = KIND_SEEK;
    r.target = t;
    queued_requests.push_back(r);
  endfunction

  function automatic void add_data(input logic [7:0] b);
    decrypt_req_t r;
    r        = scrambled_request();
    r.kind   = KIND_DATA;
    r.cipher = b;
    queued_requests.push_back(r);
  endfunction

  function automatic void add_unused();
    decrypt_req_t r;
    r      = scrambled_request();
    r.kind = KIND_UNUSED;
    queued_requests.push_back(r);
  endfunction

  // edge cases at the reset lcg terms
  function automatic void directed_cases();
    add_data(8'h3c);                   // data with empty entry after reset
    add_seek(32'd0);                   // seek onto current position, size zero
    add_seek(32'd5);                   // refused, size zero
    add_unused();
    add_open(32'hffff_ffff, 32'hffff_ffff);
    add_data(8'hff);
    add_data(8'h00);
    add_data(8'ha5);
    add_data(8'h5a);                   // crosses a dword, key steps
    add_seek(32'hffff_fffe);           // widest forward jump
    add_data(8'hff);
    add_data(8'h81);
    add_seek(32'hffff_ffff);           // onto current position at size, ok
    add_seek(32'd6);                   // backward, rewinds then jumps
    add_seek(32'd6);                   // onto current position
    add_open(32'h1234_5678, 32'd3);
    add_data(8'h11);
    add_data(8'h22);
    add_data(8'h33);
    add_data(8'h44);                   // past end
    add_seek(32'd3);                   // current position at size stays ok
    add_seek(32'd1);                   // backward within entry
    add_data(8'h99);
    add_open(32'h0, 32'h0);
    add_seek(32'hffff_ffff);
  endfunction

  // mostly well-formed entries: open, byte runs, seeks; some noise
  function automatic void stream_entries(input int count);
    int made;
    int run;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0: begin
          if ($urandom_range(0, 1)) add_unused();
          else queued_requests.push_back(scrambled_request());
          made++;
        end
        1, 2: begin
          case ($urandom_range(0, 7))
            0:       add_open($urandom(), $urandom());
            1:       add_open($urandom(), 32'd0);
            default: add_open($urandom(), $urandom_range(1, 48));
          endcase
          made++;
        end
        3: begin
          case ($urandom_range(0, 5))
            0:       add_seek($urandom());
            1:       add_seek(planned_size);
            default: add_seek(planned_size == 0 ? 32'd0 : $urandom_range(0, planned_size - 1));
          endcase
          made++;
        end
        default: begin
          run = $urandom_range(1, 12);
          for (int j = 0; j < run && made < count; j++) begin
            add_data(8'($urandom_range(0, 255)));
            made++;
          end
        end
      endcase
    end
  endfunction

  // reset, then phases at several lcg settings
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_cases();
    stream_entries(100);
    program_lcg(32'h0, 32'h0);
    stream_entries(80);
    program_lcg(32'hffff_ffff, 32'hffff_ffff);
    stream_entries(80);
    program_lcg(32'h1, $urandom());
    stream_entries(80);
    program_lcg($urandom(), $urandom());
    stream_entries(160);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (predicted_outputs.size() != 0)
      note_failure($sformatf("%0d results never arrived", predicted_outputs.size()));
    $display("covered %0d requests: %0d open, %0d seek, %0d data, %0d unused kind",
             requests_taken, n_open, n_seek, n_data, n_unused);
    $display("%0d key jumps, %0d refused seeks, %0d reads past end, %0d lcg settings",
             n_jumps, n_refused, n_past_end, n_settings);
    if (mismatches == 0) begin
      $display("lcg_keystream_seekable_decrypt_top_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("lcg_keystream_seekable_decrypt_top_tb failed");
    end
    $finish;
  end

endmodule
